// ----- rtl/core/mfe_pkg.sv -----
// Shared types, constants and the CRC-8 byte update for the motion frame encoder.
// No dependencies; every other file of the block refers to it by scoped names.
package mfe_pkg;

  // Frame layout
  localparam int FRAME_LEN = 19;
  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_CRC   = IDX_W'(11);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(FRAME_LEN - 1);

  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [7:0] END_BYTE   = 8'hFF;
  localparam logic [7:0] CRC_POLY   = 8'h07;
  localparam logic [7:0] CRC_INIT   = 8'h00;

  // Field widths and accepted ranges
  localparam int CMD_W = 8;
  localparam int POS_W = 21;
  localparam int VEL_W = 15;
  localparam int SM_W  = 24;
  localparam int TC_W  = 16;

  localparam logic signed [POS_W-1:0] POS_MIN = -21'sd999998;
  localparam logic signed [POS_W-1:0] POS_MAX = 21'sd999999;
  localparam logic signed [VEL_W-1:0] VEL_MIN = -15'sd10000;
  localparam logic signed [VEL_W-1:0] VEL_MAX = 15'sd10000;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // One classified request as it waits for the back end
  typedef struct packed {
    logic                 ok;
    logic [CMD_W-1:0]     cmd;
    logic [2:0][SM_W-1:0] pos_sm;
    logic [2:0][TC_W-1:0] vel_tc;
  } frame_entry_t;

  // CRC-8, MSB first, no reflection: fold one byte into the running value
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/mfe_front.sv -----
// Front end: range check of one request and conversion of its fields to frame form.
// Depends on mfe_pkg; feeds mfe_queue.
module mfe_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mfe_pkg::CMD_W-1:0]     in_command_code,
  input  logic signed [mfe_pkg::POS_W-1:0] in_x_position,
  input  logic signed [mfe_pkg::POS_W-1:0] in_y_position,
  input  logic signed [mfe_pkg::POS_W-1:0] in_z_position,
  input  logic signed [mfe_pkg::VEL_W-1:0] in_x_velocity,
  input  logic signed [mfe_pkg::VEL_W-1:0] in_y_velocity,
  input  logic signed [mfe_pkg::VEL_W-1:0] in_z_velocity,
  output logic                          push_valid,
  input  logic                          push_ready,
  output mfe_pkg::frame_entry_t         push_entry
);

  logic signed [mfe_pkg::POS_W-1:0] pos [3];
  logic signed [mfe_pkg::VEL_W-1:0] vel [3];
  logic [2:0]                       pos_ok;
  logic [2:0]                       vel_ok;
  logic [mfe_pkg::POS_W-1:0]        mag [3];

  assign pos[0] = in_x_position;
  assign pos[1] = in_y_position;
  assign pos[2] = in_z_position;
  assign vel[0] = in_x_velocity;
  assign vel[1] = in_y_velocity;
  assign vel[2] = in_z_velocity;

  // Check ranges and build sign-magnitude positions, widened velocities
  always_comb begin
    push_entry     = '0;
    push_entry.cmd = in_command_code;
    for (int i = 0; i < 3; i++) begin
      pos_ok[i] = (pos[i] >= mfe_pkg::POS_MIN) && (pos[i] <= mfe_pkg::POS_MAX);
      vel_ok[i] = (vel[i] >= mfe_pkg::VEL_MIN) && (vel[i] <= mfe_pkg::VEL_MAX);
      mag[i]    = pos[i][mfe_pkg::POS_W-1] ? (~pos[i] + 1'b1) : pos[i];
      push_entry.pos_sm[2-i] = {pos[i][mfe_pkg::POS_W-1],
                                (mfe_pkg::SM_W-1-mfe_pkg::POS_W)'(0), mag[i]};
      push_entry.vel_tc[2-i] = mfe_pkg::TC_W'(vel[i]);
    end
    push_entry.ok = (&pos_ok) & (&vel_ok);
  end

  // Pass the request straight into the queue
  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

// ----- rtl/core/mfe_queue.sv -----
// Short FIFO of classified requests between the front end and the byte sequencer.
// Depends on mfe_pkg for the entry type.
module mfe_queue #(
  parameter int DEPTH = mfe_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  mfe_pkg::frame_entry_t push_entry,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output mfe_pkg::frame_entry_t pop_entry
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  mfe_pkg::frame_entry_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = entry_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_MAX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_MAX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue fill level above depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CNT_FULL) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with fill level");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue fill level did not grow on push");

endmodule

// ----- rtl/core/mfe_back.sv -----
// Back end: walks the head request's frame one byte per cycle unless stalled, folds the
// CRC over the leading bytes and holds the byte in the output register. Uses mfe_pkg.
module mfe_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  mfe_pkg::frame_entry_t pop_entry,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_frame_byte,
  output logic                  out_last_byte,
  output logic                  out_encode_ok
);

  logic [mfe_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]                crc_r, crc_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [7:0]                byte_r, byte_nxt;
  logic                      last_r, last_nxt;
  logic                      ok_r, ok_nxt;
  logic [7:0]                frame_bytes [mfe_pkg::FRAME_LEN];
  logic [7:0]                cur_byte;
  logic                      advance;
  logic                      item_done;

  // Lay out the frame of the head request; the CRC slot is filled live
  always_comb begin
    frame_bytes[0] = mfe_pkg::START_BYTE;
    frame_bytes[1] = pop_entry.cmd;
    for (int p = 0; p < 3; p++) begin
      frame_bytes[2 + 3*p] = pop_entry.pos_sm[2-p][23:16];
      frame_bytes[3 + 3*p] = pop_entry.pos_sm[2-p][15:8];
      frame_bytes[4 + 3*p] = pop_entry.pos_sm[2-p][7:0];
      frame_bytes[12 + 2*p] = pop_entry.vel_tc[2-p][15:8];
      frame_bytes[13 + 2*p] = pop_entry.vel_tc[2-p][7:0];
    end
    frame_bytes[11] = crc_r;
    frame_bytes[mfe_pkg::FRAME_LEN-1] = mfe_pkg::END_BYTE;
  end

  assign cur_byte  = (idx_r == mfe_pkg::IDX_CRC) ? crc_r : frame_bytes[idx_r];
  assign advance   = pop_valid & (~out_valid_r | out_ready);
  assign item_done = ~pop_entry.ok | (idx_r == mfe_pkg::IDX_LAST);
  assign pop_ready = advance & item_done;

  // Step through the frame, load the output register, drop the request at its end
  always_comb begin
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    ok_nxt        = ok_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      byte_nxt      = pop_entry.ok ? cur_byte : 8'h00;
      last_nxt      = item_done;
      ok_nxt        = pop_entry.ok;
      if (item_done) begin
        idx_nxt = mfe_pkg::IDX_FIRST;
        crc_nxt = mfe_pkg::CRC_INIT;
      end else begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r < mfe_pkg::IDX_CRC) begin
          crc_nxt = mfe_pkg::crc8_byte(crc_r, cur_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= mfe_pkg::IDX_FIRST;
      crc_r       <= mfe_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payload of the output register
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    ok_r   <= ok_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = byte_r;
  assign out_last_byte  = last_r;
  assign out_encode_ok  = ok_r;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= mfe_pkg::IDX_LAST)
    else $error("frame byte index past end of frame");

  a_crc_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r == mfe_pkg::IDX_FIRST) |-> (crc_r == mfe_pkg::CRC_INIT))
    else $error("CRC not cleared at start of frame");

  a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !ok_r) |-> (last_r && byte_r == 8'h00))
    else $error("rejected request not a single zero byte with last set");

  a_mid_frame_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != mfe_pkg::IDX_FIRST) |-> (pop_valid && pop_entry.ok))
    else $error("frame walk in progress without an accepted head request");

endmodule

// ----- rtl/core/motion_frame_encoder_crc8_core.sv -----
// Top level of the motion frame encoder: front end, request queue, byte sequencer.
// Depends on mfe_pkg, mfe_front, mfe_queue and mfe_back.
//
// Each accepted request (command byte, three positions in 1e-4 units, three
// velocities in 1e-2 units) becomes a 19-byte frame on the out_ channel, one
// byte per cycle while out_ready is high: 0xAA, command, three 3-byte
// sign-magnitude positions, CRC-8 (poly 0x07, init 0) over bytes 0..10, three
// 2-byte two's complement velocities, 0xFF. A request with any position outside
// -999998..999999 or any velocity outside -10000..10000 yields a single result
// with encode_ok low, last_byte high and a zero byte. Requests are range-checked
// and queued on acceptance; the request whose frame is streaming keeps its queue
// slot until its last byte, so up to QUEUE_DEPTH-1 further requests are taken
// while a frame is still streaming out. An accepted request waits in its queue
// slot, and each of its bytes passes through the output register.
module motion_frame_encoder_crc8_core #(
  parameter int QUEUE_DEPTH = mfe_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mfe_pkg::CMD_W-1:0]        in_command_code,
  input  logic signed [mfe_pkg::POS_W-1:0] in_x_position,
  input  logic signed [mfe_pkg::POS_W-1:0] in_y_position,
  input  logic signed [mfe_pkg::POS_W-1:0] in_z_position,
  input  logic signed [mfe_pkg::VEL_W-1:0] in_x_velocity,
  input  logic signed [mfe_pkg::VEL_W-1:0] in_y_velocity,
  input  logic signed [mfe_pkg::VEL_W-1:0] in_z_velocity,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_frame_byte,
  output logic                             out_last_byte,
  output logic                             out_encode_ok
);

  logic                  push_valid, push_ready;
  logic                  pop_valid, pop_ready;
  mfe_pkg::frame_entry_t push_entry, pop_entry;

  // Classify and convert the incoming request
  mfe_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command_code (in_command_code),
    .in_x_position   (in_x_position),
    .in_y_position   (in_y_position),
    .in_z_position   (in_z_position),
    .in_x_velocity   (in_x_velocity),
    .in_y_velocity   (in_y_velocity),
    .in_z_velocity   (in_z_velocity),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_entry      (push_entry)
  );

  // Buffer classified requests
  mfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // Stream the frame bytes
  mfe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_entry      (pop_entry),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte),
    .out_encode_ok  (out_encode_ok)
  );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for motion_frame_encoder_crc8_core: directed table, then random requests.
// Depends on mfe_pkg for port widths; a local frame encoder predicts every output byte.
module testbench;

  // Accepted ranges, frame constants and run limits
  localparam int          POS_LO      = -999998;
  localparam int          POS_HI      = 999999;
  localparam int          VEL_LO      = -10000;
  localparam int          VEL_HI      = 10000;
  localparam int          FRAME_BYTES = 19;
  localparam int          CRC_SPAN    = 11;
  localparam logic [7:0]  SYNC_BYTE   = 8'hAA;
  localparam logic [7:0]  TAIL_BYTE   = 8'hFF;
  localparam logic [7:0]  CRC8_POLY   = 8'h07;
  localparam int          RANDOM_REQS = 135;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          DRAIN_WAIT  = 25;

  typedef struct {
    logic [7:0]         cmd;
    logic signed [20:0] pos [3];
    logic signed [14:0] vel [3];
    bit                 typed_reject;
  } motion_req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
    logic       encode_ok;
  } frame_beat_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [mfe_pkg::CMD_W-1:0] in_command_code;
  logic signed [mfe_pkg::POS_W-1:0] in_x_position;
  logic signed [mfe_pkg::POS_W-1:0] in_y_position;
  logic signed [mfe_pkg::POS_W-1:0] in_z_position;
  logic signed [mfe_pkg::VEL_W-1:0] in_x_velocity;
  logic signed [mfe_pkg::VEL_W-1:0] in_y_velocity;
  logic signed [mfe_pkg::VEL_W-1:0] in_z_velocity;
  logic out_valid;
  logic out_ready;
  logic [7:0] out_frame_byte;
  logic out_last_byte;
  logic out_encode_ok;

  // Expected output bytes, oldest first
  frame_beat_t expected_frame_bytes [$];
  motion_req_t directed_rows [$];
  bit          req_typed_reject;
  bit          quiet_phase;
  int          error_count;
  int          requests_sent;
  int          rejects_sent;
  int          bytes_checked;
  int          cycle_count;

  motion_frame_encoder_crc8_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command_code (in_command_code),
    .in_x_position   (in_x_position),
    .in_y_position   (in_y_position),
    .in_z_position   (in_z_position),
    .in_x_velocity   (in_x_velocity),
    .in_y_velocity   (in_y_velocity),
    .in_z_velocity   (in_z_velocity),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_byte  (out_frame_byte),
    .out_last_byte   (out_last_byte),
    .out_encode_ok   (out_encode_ok)
  );

  // Clock: one unit high, one unit low
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    if (quiet_phase) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Encode one request into its expected output bytes
  function automatic void predict_frame(input motion_req_t r);
    logic [7:0]  frame [FRAME_BYTES];
    logic [7:0]  crc;
    logic [23:0] sm;
    logic [15:0] tc;
    int          p;
    int          v;
    bit          good;
    good = 1'b1;
    for (int i = 0; i < 3; i++) begin
      p = r.pos[i];
      v = r.vel[i];
      if (p < POS_LO || p > POS_HI || v < VEL_LO || v > VEL_HI) good = 1'b0;
    end
    if (!good) begin
      expected_frame_bytes.push_back('{8'h00, 1'b1, 1'b0});
      return;
    end
    frame[0] = SYNC_BYTE;
    frame[1] = r.cmd;
    for (int i = 0; i < 3; i++) begin
      p = r.pos[i];
      v = r.vel[i];
      sm = {p < 0, 23'((p < 0) ? -p : p)};
      tc = 16'(v);
      frame[2 + 3 * i] = sm[23:16];
      frame[3 + 3 * i] = sm[15:8];
      frame[4 + 3 * i] = sm[7:0];
      frame[12 + 2 * i] = tc[15:8];
      frame[13 + 2 * i] = tc[7:0];
    end
    // CRC-8 MSB first over the header and positions
    crc = 8'h00;
    for (int n = 0; n < CRC_SPAN; n++) begin
      crc = crc ^ frame[n];
      for (int b = 0; b < 8; b++) begin
        crc = crc[7] ? ((crc << 1) ^ CRC8_POLY) : (crc << 1);
      end
    end
    frame[11] = crc;
    frame[18] = TAIL_BYTE;
    for (int n = 0; n < FRAME_BYTES; n++) begin
      expected_frame_bytes.push_back('{frame[n], n == FRAME_BYTES - 1, 1'b1});
    end
  endfunction

  function automatic motion_req_t make_row(input int cmd, input int xp, input int yp,
                                           input int zp, input int xv, input int yv,
                                           input int zv, input bit rej);
    motion_req_t r;
    r.cmd          = 8'(cmd);
    r.pos[0]       = 21'(xp);
    r.pos[1]       = 21'(yp);
    r.pos[2]       = 21'(zp);
    r.vel[0]       = 15'(xv);
    r.vel[1]       = 15'(yv);
    r.vel[2]       = 15'(zv);
    r.typed_reject = rej;
    return r;
  endfunction

  // Idle a random gap, present one request, hold it until accepted, return at the next falling edge
  task automatic send_request(input motion_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_command_code  <= r.cmd;
    in_x_position    <= r.pos[0];
    in_y_position    <= r.pos[1];
    in_z_position    <= r.pos[2];
    in_x_velocity    <= r.vel[0];
    in_y_velocity    <= r.vel[1];
    in_z_velocity    <= r.vel[2];
    req_typed_reject <= r.typed_reject;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  // Predict on each accepted request, check each accepted output byte
  always @(posedge clk) begin : scoreboard
    motion_req_t seen;
    frame_beat_t want;
    if (rst_n && in_valid && in_ready) begin
      seen.cmd    = in_command_code;
      seen.pos[0] = in_x_position;
      seen.pos[1] = in_y_position;
      seen.pos[2] = in_z_position;
      seen.vel[0] = in_x_velocity;
      seen.vel[1] = in_y_velocity;
      seen.vel[2] = in_z_velocity;
      requests_sent++;
      if (req_typed_reject) begin
        expected_frame_bytes.push_back('{8'h00, 1'b1, 1'b0});
      end else begin
        predict_frame(seen);
      end
      if (expected_frame_bytes[$].encode_ok === 1'b0) rejects_sent++;
    end
    if (rst_n && out_valid && out_ready) begin
      bytes_checked++;
      if (expected_frame_bytes.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected output byte %02h last %0b ok %0b with nothing pending",
                   out_frame_byte, out_last_byte, out_encode_ok);
      end else begin
        want = expected_frame_bytes.pop_front();
        if (out_frame_byte !== want.frame_byte || out_last_byte !== want.last_byte ||
            out_encode_ok !== want.encode_ok) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected byte %02h last %0b ok %0b, got byte %02h last %0b ok %0b",
                     want.frame_byte, want.last_byte, want.encode_ok,
                     out_frame_byte, out_last_byte, out_encode_ok);
        end
      end
    end
  end

  // Watchdog on total run length
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: alternate ready runs with stalls of random length
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin : ready_loop
      int stall;
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
  end

  // Stimulus
  initial begin : stimulus
    motion_req_t r;
    int          tmp;
    int          pick;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_command_code  = '0;
    in_x_position    = '0;
    in_y_position    = '0;
    in_z_position    = '0;
    in_x_velocity    = '0;
    in_y_velocity    = '0;
    in_z_velocity    = '0;
    req_typed_reject = 1'b0;
    quiet_phase      = 1'b0;
    error_count      = 0;
    requests_sent    = 0;
    rejects_sent     = 0;
    bytes_checked    = 0;
    cycle_count      = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows: range edges, zero, sign handling, each way to be rejected
    directed_rows.push_back(make_row(8'h00, 0, 0, 0, 0, 0, 0, 1'b0));
    directed_rows.push_back(make_row(8'hFF, POS_HI, POS_HI, POS_HI, VEL_HI, VEL_HI, VEL_HI, 1'b0));
    directed_rows.push_back(make_row(8'h5A, POS_LO, POS_LO, POS_LO, VEL_LO, VEL_LO, VEL_LO, 1'b0));
    directed_rows.push_back(make_row(8'h01, -1, 1, -1, -1, 1, -1, 1'b0));
    directed_rows.push_back(make_row(8'h81, POS_HI, POS_LO, 0, VEL_HI, VEL_LO, 0, 1'b0));
    directed_rows.push_back(make_row(8'h3C, 123456, -654321, 42, 1234, -4321, 7, 1'b0));
    directed_rows.push_back(make_row(8'h10, -999999, 0, 0, 0, 0, 0, 1'b1));
    directed_rows.push_back(make_row(8'h11, 0, 1000000, 0, 0, 0, 0, 1'b1));
    directed_rows.push_back(make_row(8'h12, 0, 0, -1048576, 0, 0, 0, 1'b1));
    directed_rows.push_back(make_row(8'h13, 0, 0, 1048575, 0, 0, 0, 1'b1));
    directed_rows.push_back(make_row(8'h14, 0, 0, 0, 10001, 0, 0, 1'b1));
    directed_rows.push_back(make_row(8'h15, 0, 0, 0, 0, -10001, 0, 1'b1));
    directed_rows.push_back(make_row(8'h16, 0, 0, 0, 0, 0, -16384, 1'b1));
    directed_rows.push_back(make_row(8'h17, 0, 0, 0, 0, 0, 16383, 1'b1));
    directed_rows.push_back(make_row(8'hFF, -1048576, 1048575, -1048576,
                                     -16384, 16383, -16384, 1'b1));
    directed_rows.push_back(make_row(8'hC3, 500000, -500000, 999998, -9999, 9999, 256, 1'b0));
    foreach (directed_rows[k]) send_request(directed_rows[k]);

    // Random requests: mostly in range, some with one value pushed out of range
    for (int k = 0; k < RANDOM_REQS; k++) begin
      quiet_phase    = (k >= 60 && k < 85);
      r.cmd          = 8'($urandom_range(0, 255));
      r.typed_reject = 1'b0;
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(0, 9))
          0: tmp = POS_HI;
          1: tmp = POS_LO;
          2: tmp = int'($urandom_range(0, 2)) - 1;
          default: tmp = int'($urandom_range(0, POS_HI - POS_LO)) + POS_LO;
        endcase
        r.pos[i] = 21'(tmp);
        case ($urandom_range(0, 9))
          0: tmp = VEL_HI;
          1: tmp = VEL_LO;
          2: tmp = int'($urandom_range(0, 2)) - 1;
          default: tmp = int'($urandom_range(0, VEL_HI - VEL_LO)) + VEL_LO;
        endcase
        r.vel[i] = 15'(tmp);
      end
      // Break about one request in five
      if ($urandom_range(0, 99) < 20) begin
        pick = $urandom_range(0, 5);
        if (pick < 3) begin
          if ($urandom_range(0, 1))
            tmp = -1048576 + int'($urandom_range(0, 48577));
          else
            tmp = 1000000 + int'($urandom_range(0, 48575));
          r.pos[pick] = 21'(tmp);
        end else begin
          if ($urandom_range(0, 1))
            tmp = -16384 + int'($urandom_range(0, 6383));
          else
            tmp = 10001 + int'($urandom_range(0, 6382));
          r.vel[pick - 3] = 15'(tmp);
        end
      end
      send_request(r);
    end
    in_valid    <= 1'b0;
    quiet_phase  = 1'b0;

    // Drain outstanding bytes, then watch for stray output
    while (expected_frame_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_frame_bytes.size() != 0) begin
      error_count++;
      $display("%0d expected bytes never arrived", expected_frame_bytes.size());
    end

    $display("Encoded %0d requests (%0d rejected by range check), %0d output bytes checked",
             requests_sent, rejects_sent, bytes_checked);
    $display("Error count: %0d", error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
